/* hw/rtl/huffman_encoder_macros.svh */
// Assertion helpers for the huffman encoder; both expect clock and reset in scope.
`ifndef HUFFMAN_ENCODER_MACROS_SVH
`define HUFFMAN_ENCODER_MACROS_SVH
`ifndef SYNTHESIS
`define HUF_ASSERT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("huffman_encoder: same-cycle check failed");
`define HUF_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("huffman_encoder: next-cycle check failed");
`else
`define HUF_ASSERT(label, ante, cons)
`define HUF_ASSERT_NEXT(label, ante, cons)
`endif
`endif

/* hw/rtl/hufenc_pkg.sv */
`default_nettype none
package hufenc_pkg;

   localparam int OP_W     = 2;
   localparam int SYM_W    = 7;
   localparam int CODE_W   = 32;
   localparam int LEN_W    = 6;
   localparam int BYTE_W   = 8;
   localparam int PEND_W   = 7;
   localparam int PCNT_W   = 3;
   // pending bits plus the longest code
   localparam int ACC_W    = PEND_W + CODE_W;
   localparam int CNT_W    = 6;
   // at most four whole bytes per item
   localparam int WIN_W    = 32;
   localparam int REM_W    = 3;

   localparam int DEF_SYMBOL_COUNT = 128;
   localparam int DEF_MAX_CODE_LEN = 32;

   typedef enum logic [OP_W-1:0] {
      OP_LOAD   = 2'd0,
      OP_ENCODE = 2'd1,
      OP_FLUSH  = 2'd2,
      OP_NOP    = 2'd3
   } op_type;

   typedef struct packed {
      logic load;
      logic read;
      logic flush;
      logic calc;
      logic align;
      logic pop;
   } dp_cmd_type;

   typedef struct packed {
      logic sym_ok;
      logic pend_empty;
      logic no_bytes;
      logic last_byte;
   } dp_status_type;

endpackage
`default_nettype wire

/* hw/rtl/hufenc_ram.sv */
`default_nettype none
module hufenc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

/* hw/rtl/hufenc_ctrl.sv */
`default_nettype none
module hufenc_ctrl (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      req_valid,
   output logic                           req_stall,
   input  wire logic [hufenc_pkg::OP_W-1:0] req_opcode,
   output logic                           rsp_valid,
   input  wire logic                      rsp_stall,
   input  wire hufenc_pkg::dp_status_type st,
   output hufenc_pkg::dp_cmd_type         cmd
);
   import hufenc_pkg::*;

   typedef enum logic [3:0] {
      ST_IDLE  = 4'b0001,
      ST_CALC  = 4'b0010,
      ST_ALIGN = 4'b0100,
      ST_OUT   = 4'b1000
   } state_type;

   state_type state_ff, state_in;
   logic      accept;

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = (state_ff == ST_OUT);
   assign accept    = req_valid && (state_ff == ST_IDLE);

   always_comb begin
      cmd       = '0;
      cmd.load  = accept && (req_opcode == OP_LOAD) && st.sym_ok;
      cmd.read  = accept && (req_opcode == OP_ENCODE) && st.sym_ok;
      cmd.flush = accept && (req_opcode == OP_FLUSH) && !st.pend_empty;
      cmd.calc  = (state_ff == ST_CALC);
      cmd.align = (state_ff == ST_ALIGN);
      cmd.pop   = (state_ff == ST_OUT) && !rsp_stall;
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (cmd.read || cmd.flush) begin
               state_in = ST_CALC;
            end
         end
         ST_CALC:  state_in = ST_ALIGN;
         ST_ALIGN: begin
            // an encode that completes no byte only updates the leftover bits
            state_in = st.no_bytes ? ST_IDLE : ST_OUT;
         end
         ST_OUT: begin
            if (!rsp_stall && st.last_byte) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule
`default_nettype wire

/* hw/rtl/hufenc_dp.sv */
`default_nettype none
module hufenc_dp #(
   parameter int SYMBOL_COUNT = hufenc_pkg::DEF_SYMBOL_COUNT,
   parameter int MAX_CODE_LEN = hufenc_pkg::DEF_MAX_CODE_LEN
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic [hufenc_pkg::SYM_W-1:0]  req_symbol,
   input  wire logic [hufenc_pkg::CODE_W-1:0] req_code_bits,
   input  wire logic [hufenc_pkg::LEN_W-1:0]  req_code_length,
   output logic      [hufenc_pkg::BYTE_W-1:0] rsp_out_byte,
   output logic                               rsp_last_of_run,
   output logic                               rsp_padded,
   input  wire hufenc_pkg::dp_cmd_type        cmd,
   output hufenc_pkg::dp_status_type          st
);
   import hufenc_pkg::*;

   localparam int AW      = $clog2(SYMBOL_COUNT);
   localparam int LEN_CAP = (MAX_CODE_LEN < CODE_W) ? MAX_CODE_LEN : CODE_W;
   localparam int ENT_W   = LEN_W + CODE_W;

   logic [AW+SYM_W-1:0] sym_ext;
   logic [AW-1:0]       addr;
   logic [LEN_W-1:0]    len_sat;
   logic [CODE_W:0]     mask_wide;
   logic [ENT_W-1:0]    wr_entry, rd_entry;
   logic [LEN_W-1:0]    len_rd;
   logic [CODE_W-1:0]   code_rd;

   logic                flush_ff, flush_in;
   logic [ACC_W-1:0]    acc_ff, acc_in;
   logic [CNT_W-1:0]    count_ff, count_in;
   logic [WIN_W-1:0]    win_ff, win_in;
   logic [REM_W-1:0]    rem_ff, rem_in;
   logic [PEND_W-1:0]   pend_bits_ff, pend_bits_in;
   logic [PCNT_W-1:0]   pend_count_ff, pend_count_in;
   logic [ACC_W-1:0]    aligned;
   logic [REM_W-1:0]    nbytes;
   logic [PEND_W-1:0]   pend_mask;

   assign sym_ext   = {{AW{1'b0}}, req_symbol};
   assign addr      = sym_ext[AW-1:0];
   assign st.sym_ok = (sym_ext < (AW+SYM_W)'(SYMBOL_COUNT));

   // clamp the length and zero the code bits above it before storing
   assign len_sat   = (req_code_length > LEN_W'(LEN_CAP)) ? LEN_W'(LEN_CAP) : req_code_length;
   assign mask_wide = ~({(CODE_W+1){1'b1}} << len_sat);
   assign wr_entry  = {len_sat, req_code_bits & mask_wide[CODE_W-1:0]};

   hufenc_ram #(
      .WIDTH (ENT_W),
      .DEPTH (SYMBOL_COUNT)
   ) u_table (
      .clock   (clock),
      .wr_en   (cmd.load),
      .wr_addr (addr),
      .wr_data (wr_entry),
      .rd_en   (cmd.read),
      .rd_addr (addr),
      .rd_data (rd_entry)
   );

   assign len_rd  = rd_entry[ENT_W-1 -: LEN_W];
   assign code_rd = rd_entry[CODE_W-1:0];

   assign aligned   = acc_ff << (CNT_W'(ACC_W) - count_ff);
   assign nbytes    = flush_ff ? REM_W'(1) : count_ff[CNT_W-1:3];
   assign pend_mask = ~({PEND_W{1'b1}} << count_ff[2:0]);

   always_comb begin
      flush_in      = flush_ff;
      acc_in        = acc_ff;
      count_in      = count_ff;
      win_in        = win_ff;
      rem_in        = rem_ff;
      pend_bits_in  = pend_bits_ff;
      pend_count_in = pend_count_ff;
      if (cmd.read || cmd.flush) begin
         flush_in = cmd.flush;
      end
      if (cmd.calc) begin
         if (flush_ff) begin
            acc_in   = ACC_W'(pend_bits_ff);
            count_in = CNT_W'(pend_count_ff);
         end else begin
            acc_in   = (ACC_W'(pend_bits_ff) << len_rd) | ACC_W'(code_rd);
            count_in = CNT_W'(pend_count_ff) + len_rd;
         end
      end
      if (cmd.align) begin
         // earliest bit to the top, zeros fill behind it (padding on flush)
         win_in = aligned[ACC_W-1 -: WIN_W];
         rem_in = nbytes;
         if (flush_ff) begin
            pend_bits_in  = '0;
            pend_count_in = '0;
         end else begin
            pend_bits_in  = acc_ff[PEND_W-1:0] & pend_mask;
            pend_count_in = count_ff[2:0];
         end
      end
      if (cmd.pop) begin
         win_in = win_ff << BYTE_W;
         rem_in = rem_ff - REM_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      acc_ff   <= acc_in;
      count_ff <= count_in;
      win_ff   <= win_in;
      flush_ff <= flush_in;
      if (reset) begin
         rem_ff        <= '0;
         pend_bits_ff  <= '0;
         pend_count_ff <= '0;
      end else begin
         rem_ff        <= rem_in;
         pend_bits_ff  <= pend_bits_in;
         pend_count_ff <= pend_count_in;
      end
   end

   assign st.pend_empty = (pend_count_ff == '0);
   assign st.no_bytes   = (nbytes == '0);
   assign st.last_byte  = (rem_ff == REM_W'(1));

   assign rsp_out_byte    = win_ff[WIN_W-1 -: BYTE_W];
   assign rsp_last_of_run = st.last_byte;
   assign rsp_padded      = flush_ff;

endmodule
`default_nettype wire

/* hw/rtl/huffman_encoder.sv */
`default_nettype none
`include "huffman_encoder_macros.svh"
// Huffman encoder with a loadable code table held in a single-port-write RAM
// (one entry per symbol: code and clamped length). Items are handled one at a
// time. A load, an ignored opcode, an out-of-range symbol or a flush with no
// leftover bits is done when it is accepted. An encode or a flush that releases
// N bytes (0 to 4) goes through the registered table read (encode only), the
// merge of the code with the leftover bits and the MSB-first alignment of the
// bits, then gives one byte per cycle on the response side while it is not
// stalled. Table entries read before being loaded return garbage; there is no
// clearing pass after reset.
module huffman_encoder #(
   parameter int SYMBOL_COUNT = hufenc_pkg::DEF_SYMBOL_COUNT,
   parameter int MAX_CODE_LEN = hufenc_pkg::DEF_MAX_CODE_LEN
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   output logic                               req_stall,
   input  wire logic [hufenc_pkg::OP_W-1:0]   req_opcode,
   input  wire logic [hufenc_pkg::SYM_W-1:0]  req_symbol,
   input  wire logic [hufenc_pkg::CODE_W-1:0] req_code_bits,
   input  wire logic [hufenc_pkg::LEN_W-1:0]  req_code_length,
   output logic                               rsp_valid,
   input  wire logic                          rsp_stall,
   output logic      [hufenc_pkg::BYTE_W-1:0] rsp_out_byte,
   output logic                               rsp_last_of_run,
   output logic                               rsp_padded
);
   import hufenc_pkg::*;

   dp_cmd_type    cmd;
   dp_status_type st;

   hufenc_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_opcode (req_opcode),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .st         (st),
      .cmd        (cmd)
   );

   hufenc_dp #(
      .SYMBOL_COUNT (SYMBOL_COUNT),
      .MAX_CODE_LEN (MAX_CODE_LEN)
   ) u_dp (
      .clock           (clock),
      .reset           (reset),
      .req_symbol      (req_symbol),
      .req_code_bits   (req_code_bits),
      .req_code_length (req_code_length),
      .rsp_out_byte    (rsp_out_byte),
      .rsp_last_of_run (rsp_last_of_run),
      .rsp_padded      (rsp_padded),
      .cmd             (cmd),
      .st              (st)
   );

   `HUF_ASSERT(a_busy_while_out, rsp_valid, req_stall)
   `HUF_ASSERT(a_pad_is_last, rsp_valid && rsp_padded, rsp_last_of_run)
   `HUF_ASSERT_NEXT(a_run_ends, rsp_valid && !rsp_stall && rsp_last_of_run, !rsp_valid)
   `HUF_ASSERT_NEXT(a_load_quiet, req_valid && !req_stall && (req_opcode == OP_LOAD),
                    !rsp_valid && !req_stall)

endmodule
`default_nettype wire

/* tb/sv/huffman_encoder_test.sv */
`timescale 1ns / 100ps

module huffman_encoder_test;
   import hufenc_pkg::*;

   localparam int IDLE_LIMIT = 2000;
   localparam int RANDOM_ITEMS = 134;
   localparam int TAIL_CYCLES = 30;

   typedef struct {
      op_type            op;
      logic [SYM_W-1:0]  sym;
      logic [CODE_W-1:0] code;
      logic [LEN_W-1:0]  len;
      bit                drain;
   } huf_item_type;

   typedef struct {
      logic [BYTE_W-1:0] data;
      logic              last;
      logic              pad;
   } huf_byte_type;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_stall;
   logic [OP_W-1:0]   req_opcode = OP_NOP;
   logic [SYM_W-1:0]  req_symbol = '0;
   logic [CODE_W-1:0] req_code_bits = '0;
   logic [LEN_W-1:0]  req_code_length = '0;
   logic              rsp_valid;
   logic              rsp_stall = 1'b0;
   logic [BYTE_W-1:0] rsp_out_byte;
   logic              rsp_last_of_run;
   logic              rsp_padded;

   huffman_encoder u_top (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_opcode      (req_opcode),
      .req_symbol      (req_symbol),
      .req_code_bits   (req_code_bits),
      .req_code_length (req_code_length),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_out_byte    (rsp_out_byte),
      .rsp_last_of_run (rsp_last_of_run),
      .rsp_padded      (rsp_padded)
   );

   always #1 clock = ~clock;

   huf_item_type      stim_items[$];
   huf_byte_type      byte_queue[$];
   huf_item_type      cur_item;
   int                errors = 0;
   int                idle_cycles = 0;

   // predictor state
   logic [CODE_W-1:0] code_table[DEF_SYMBOL_COUNT];
   logic [LEN_W-1:0]  length_table[DEF_SYMBOL_COUNT];
   logic [PEND_W-1:0] pend_bits = '0;
   logic [PCNT_W-1:0] pend_count = '0;

   // stimulus bookkeeping: which symbols have a loaded entry
   bit                gen_loaded[DEF_SYMBOL_COUNT];
   int                loaded_syms[$];

   task automatic report_mismatch(string what, int got, int want);
      $display("%0t: %s: got %0h, expected %0h", $realtime, what, got, want);
      errors++;
   endtask

   task automatic queue_item(op_type op, int sym, logic [CODE_W-1:0] code, int len,
                             bit drain = 1'b0);
      huf_item_type it;
      it.op = op;
      it.sym = SYM_W'(sym);
      it.code = code;
      it.len = LEN_W'(len);
      it.drain = drain;
      stim_items.push_back(it);
      if (op == OP_LOAD && !gen_loaded[sym]) begin
         gen_loaded[sym] = 1'b1;
         loaded_syms.push_back(sym);
      end
   endtask

   // Work out the bytes one accepted beat releases and update the bit buffer.
   task automatic encode_beat(huf_item_type it);
      logic [63:0]  acc;
      int           l;
      int           cnt;
      huf_byte_type b;
      case (it.op)
         OP_LOAD: begin
            if (it.sym < DEF_SYMBOL_COUNT) begin
               l = int'(it.len);
               if (l > DEF_MAX_CODE_LEN) l = DEF_MAX_CODE_LEN;
               if (l > CODE_W) l = CODE_W;
               code_table[it.sym] = it.code;
               length_table[it.sym] = LEN_W'(l);
            end
         end
         OP_ENCODE: begin
            if (it.sym < DEF_SYMBOL_COUNT) begin
               l = int'(length_table[it.sym]);
               acc = (64'(pend_bits) << l) | (64'(code_table[it.sym]) & ((64'd1 << l) - 1));
               cnt = int'(pend_count) + l;
               while (cnt >= BYTE_W) begin
                  b.data = BYTE_W'(acc >> (cnt - BYTE_W));
                  cnt -= BYTE_W;
                  b.last = (cnt < BYTE_W);
                  b.pad = 1'b0;
                  byte_queue.push_back(b);
               end
               pend_count = PCNT_W'(cnt);
               pend_bits = PEND_W'(acc & ((64'd1 << cnt) - 1));
            end
         end
         OP_FLUSH: begin
            if (pend_count != 0) begin
               b.data = BYTE_W'(16'(pend_bits) << (BYTE_W - int'(pend_count)));
               b.last = 1'b1;
               b.pad = 1'b1;
               byte_queue.push_back(b);
               pend_bits = '0;
               pend_count = '0;
            end
         end
         default: ;
      endcase
   endtask

   // sender: bursts of random length, random gaps, holds before drain items
   int burst_left = 4;
   int gap_left = 0;

   always @(posedge clock) begin : drive
      huf_item_type nxt;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) encode_beat(cur_item);
         if (!(req_valid && req_stall)) begin
            if (gap_left > 0) begin
               gap_left--;
               req_valid <= 1'b0;
            end else if (stim_items.size() == 0 ||
                         (stim_items[0].drain && byte_queue.size() != 0)) begin
               req_valid <= 1'b0;
            end else begin
               nxt = stim_items.pop_front();
               cur_item = nxt;
               req_valid <= 1'b1;
               req_opcode <= nxt.op;
               req_symbol <= nxt.sym;
               req_code_bits <= nxt.code;
               req_code_length <= nxt.len;
               burst_left--;
               if (burst_left <= 0) begin
                  gap_left = ($urandom_range(3) == 0) ? 0 : $urandom_range(8, 1);
                  burst_left = ($urandom_range(4) == 0) ? $urandom_range(40, 20)
                                                        : $urandom_range(6, 1);
               end
            end
         end
      end
   end

   // receiver: stall pattern rotates through four modes, chosen from stall_phase
   int stall_phase = 0;
   int long_left = 0;

   always @(posedge clock) begin : observe
      huf_byte_type want;
      logic         stall_next;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (byte_queue.size() == 0) begin
               report_mismatch("byte with nothing expected", int'(rsp_out_byte), 0);
            end else begin
               want = byte_queue.pop_front();
               if (rsp_out_byte !== want.data)
                  report_mismatch("out_byte", int'(rsp_out_byte), int'(want.data));
               if (rsp_last_of_run !== want.last)
                  report_mismatch("last_of_run", int'(rsp_last_of_run), int'(want.last));
               if (rsp_padded !== want.pad)
                  report_mismatch("padded", int'(rsp_padded), int'(want.pad));
            end
         end
         stall_phase++;
         case ((stall_phase >> 6) % 4)
            0: stall_next = 1'b0;
            1: stall_next = ($urandom_range(2) == 0);
            2: stall_next = stall_phase[0];
            default: begin
               if (long_left > 0) begin
                  long_left--;
                  stall_next = 1'b1;
               end else begin
                  if ($urandom_range(7) == 0) long_left = $urandom_range(15, 1);
                  stall_next = 1'b0;
               end
            end
         endcase
         rsp_stall <= stall_next;
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      int n;
      int r;
      int l;
      // directed: length extremes, saturation, empty flush, unused opcode
      queue_item(OP_LOAD, 0, 32'h0, 0);
      queue_item(OP_LOAD, 127, 32'hFFFF_FFFF, 32);
      queue_item(OP_LOAD, 1, 32'h1, 1);
      queue_item(OP_LOAD, 2, 32'h5, 3);
      queue_item(OP_LOAD, 3, $urandom, 63);
      queue_item(OP_LOAD, 5, 32'hFFFF_FFFF, 4);
      queue_item(OP_LOAD, 6, 32'h1234_5678, 40);
      queue_item(OP_FLUSH, 0, 32'h0, 0);
      queue_item(OP_ENCODE, 0, 32'h0, 0);
      queue_item(OP_ENCODE, 1, 32'h0, 0);
      queue_item(OP_FLUSH, 0, 32'h0, 0);
      queue_item(OP_ENCODE, 127, 32'h0, 0);
      queue_item(OP_ENCODE, 1, 32'h0, 0);
      queue_item(OP_ENCODE, 127, 32'h0, 0);
      queue_item(OP_ENCODE, 5, 32'h0, 0);
      queue_item(OP_ENCODE, 3, 32'h0, 0);
      queue_item(OP_NOP, 127, 32'hFFFF_FFFF, 63);
      queue_item(OP_ENCODE, 6, 32'h0, 0);
      queue_item(OP_FLUSH, 0, 32'h0, 0);
      queue_item(OP_ENCODE, 2, 32'h0, 0);
      queue_item(OP_ENCODE, 2, 32'h0, 0);
      queue_item(OP_ENCODE, 2, 32'h0, 0);
      queue_item(OP_FLUSH, 0, 32'h0, 0, 1'b1);
      queue_item(OP_LOAD, 1, 32'hFFFF_FF2A, 7);
      queue_item(OP_ENCODE, 1, 32'h0, 0);

      n = 0;
      while (n < RANDOM_ITEMS) begin
         r = $urandom_range(99);
         if (r < 15 || loaded_syms.size() == 0) begin
            case ($urandom_range(9))
               0: l = 0;
               1: l = $urandom_range(63, 33);
               default: l = $urandom_range(32, 1);
            endcase
            queue_item(OP_LOAD, $urandom_range(127), $urandom, l);
         end else if (r < 80) begin
            // encode only symbols whose entry is loaded; other fields are don't-care
            queue_item(OP_ENCODE, loaded_syms[$urandom_range(loaded_syms.size() - 1)],
                       $urandom, $urandom_range(63), (n == 80) || ($urandom_range(49) == 0));
         end else if (r < 93) begin
            queue_item(OP_FLUSH, $urandom_range(127), $urandom, $urandom_range(63));
         end else begin
            queue_item(OP_NOP, $urandom_range(127), $urandom, $urandom_range(63));
         end
         n++;
      end
      queue_item(OP_FLUSH, 0, 32'h0, 0);

      repeat (12) @(posedge clock);
      reset <= 1'b0;

      do @(posedge clock);
      while (stim_items.size() != 0 || req_valid || byte_queue.size() != 0);
      repeat (TAIL_CYCLES) @(posedge clock);

      if (errors == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule

/* filelist.f */
+incdir+hw/rtl
hw/rtl/hufenc_pkg.sv
hw/rtl/hufenc_ram.sv
hw/rtl/hufenc_ctrl.sv
hw/rtl/hufenc_dp.sv
hw/rtl/huffman_encoder.sv
tb/sv/huffman_encoder_test.sv
